>>> hw/rtl/onb_pkg.sv
// Shared types and constants for the normal-to-orthonormal-basis pipeline.
package onb_pkg;

    // Dimension codes
    localparam logic [1:0] DIM_NONE = 2'd0;
    localparam logic [1:0] DIM_1    = 2'd1;
    localparam logic [1:0] DIM_2    = 2'd2;
    localparam logic [1:0] DIM_3    = 2'd3;

    // |z| > 0.9 is tested as THR_NUM * |z| > THR_DEN * one
    localparam int THR_NUM = 10;
    localparam int THR_DEN = 9;

    // Per-item control flags that ride along with the data
    typedef struct packed {
        logic [1:0] dim;
        logic       sel_y;     // reference axis is y
        logic       neg_a;     // sign of first raw tangent part
        logic       neg_b;     // sign of second raw tangent part
        logic       zero_len;  // raw tangent has zero length
    } onb_flags_t;

    localparam int FLAGS_W = $bits(onb_flags_t);

endpackage

>>> hw/rtl/onb_prep.sv
// Front end: reference axis choice, tangent part magnitudes and squared length.
module onb_prep
    import onb_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [1:0]                dimension,
    input  logic signed [W-1:0]       nx,
    input  logic signed [W-1:0]       ny,
    input  logic signed [W-1:0]       nz,
    output logic                      out_valid,
    output logic [W-1:0]              mag_a,
    output logic [W-1:0]              mag_b,
    output logic [2*W-1:0]            sum_sq,
    output logic [FLAGS_W+3*W-1:0]    side
);
    localparam int F = W - 2;

    // Stage A: axis select and magnitudes
    logic [W:0]   nx_ext, ny_ext, nz_ext;
    logic [W:0]   ax_w, ay_w, az_w;
    logic [W-1:0] ax, ay, az;
    logic         sel_y;
    onb_flags_t   fa_next;

    assign nx_ext = {nx[W-1], nx};
    assign ny_ext = {ny[W-1], ny};
    assign nz_ext = {nz[W-1], nz};
    assign ax_w   = nx[W-1] ? -nx_ext : nx_ext;
    assign ay_w   = ny[W-1] ? -ny_ext : ny_ext;
    assign az_w   = nz[W-1] ? -nz_ext : nz_ext;
    assign ax     = ax_w[W-1:0];
    assign ay     = ay_w[W-1:0];
    assign az     = az_w[W-1:0];
    assign sel_y  = ((W+4)'(az) * (W+4)'(THR_NUM)) > ((W+4)'(THR_DEN) << F);

    always_comb begin
        fa_next.dim      = dimension;
        fa_next.sel_y    = sel_y;
        fa_next.neg_a    = sel_y ? !nz[W-1] : ny[W-1];
        fa_next.neg_b    = sel_y ? nx[W-1] : !nx[W-1];
        fa_next.zero_len = 1'b0;
    end

    logic               va_reg, vb_reg, vc_reg;
    logic [W-1:0]       ma_a_reg, ma_b_reg, mb_a_reg, mb_b_reg, mc_a_reg, mc_b_reg;
    onb_flags_t         fa_reg, fb_reg, fc_reg;
    logic [3*W-1:0]     na_reg, nb_reg, nc_reg;
    logic [2*W-1:0]     sq_a_reg, sq_b_reg, sum_reg;
    logic [2*W-1:0]     sq_a_next, sq_b_next, sum_next;
    onb_flags_t         fc_next;

    // Stage B: squares
    assign sq_a_next = (2*W)'(ma_a_reg) * (2*W)'(ma_a_reg);
    assign sq_b_next = (2*W)'(ma_b_reg) * (2*W)'(ma_b_reg);

    // Stage C: squared length and zero test
    assign sum_next = sq_a_reg + sq_b_reg;
    always_comb begin
        fc_next          = fb_reg;
        fc_next.zero_len = (sum_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ma_a_reg <= sel_y ? az : ay;
            ma_b_reg <= ax;
            fa_reg   <= fa_next;
            na_reg   <= {nz, ny, nx};
            mb_a_reg <= ma_a_reg;
            mb_b_reg <= ma_b_reg;
            sq_a_reg <= sq_a_next;
            sq_b_reg <= sq_b_next;
            fb_reg   <= fa_reg;
            nb_reg   <= na_reg;
            mc_a_reg <= mb_a_reg;
            mc_b_reg <= mb_b_reg;
            sum_reg  <= sum_next;
            fc_reg   <= fc_next;
            nc_reg   <= nb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign mag_a     = mc_a_reg;
    assign mag_b     = mc_b_reg;
    assign sum_sq    = sum_reg;
    assign side      = {fc_reg, nc_reg};
endmodule

>>> hw/rtl/onb_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module onb_isqrt #(
    parameter int W      = 16,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [2*W-1:0]    radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      root,
    output logic [SIDE_W-1:0] out_side
);
    logic [W-1:0]      valid_reg;
    logic [2*W-1:0]    rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [SIDE_W-1:0] side_reg [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        localparam int B = W - 1 - i;
        logic              v_prev;
        logic [2*W-1:0]    rem_prev, rem_next;
        logic [W-1:0]      root_prev, root_next;
        logic [SIDE_W-1:0] side_prev;
        logic [2*W:0]      trial;
        logic              take;

        if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = radicand;
            assign root_prev = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = valid_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // try setting bit B of the root
        assign trial     = ((2*W+1)'(root_prev) << (B + 1)) + ((2*W+1)'(1) << (2 * B));
        assign take      = {1'b0, rem_prev} >= trial;
        assign rem_next  = take ? rem_prev - trial[2*W-1:0] : rem_prev;
        assign root_next = take ? (root_prev | (W'(1) << B)) : root_prev;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (adv) begin
                valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign root      = root_reg[W-1];
    assign out_side  = side_reg[W-1];
endmodule

>>> hw/rtl/onb_div.sv
// Pipelined two-lane restoring divider: (mag * one) / root, one quotient bit per stage.
module onb_div #(
    parameter int W      = 16,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [W-1:0]      mag_a,
    input  logic [W-1:0]      mag_b,
    input  logic [W-1:0]      divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-2:0]      quot_a,
    output logic [W-2:0]      quot_b,
    output logic [SIDE_W-1:0] out_side
);
    localparam int F = W - 2;
    localparam int N = W - 1;

    logic [N-1:0]      valid_reg;
    logic [2*W-1:0]    rem_a_reg [N];
    logic [2*W-1:0]    rem_b_reg [N];
    logic [W-2:0]      q_a_reg   [N];
    logic [W-2:0]      q_b_reg   [N];
    logic [W-1:0]      dv_reg    [N];
    logic [SIDE_W-1:0] side_reg  [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int B = N - 1 - i;
        logic              v_prev;
        logic [2*W-1:0]    ra_prev, rb_prev, sub;
        logic [W-2:0]      qa_prev, qb_prev;
        logic [W-1:0]      dv_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              take_a, take_b;

        if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign ra_prev   = (2*W)'(mag_a) << F;
            assign rb_prev   = (2*W)'(mag_b) << F;
            assign qa_prev   = '0;
            assign qb_prev   = '0;
            assign dv_prev   = divisor;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = valid_reg[i-1];
            assign ra_prev   = rem_a_reg[i-1];
            assign rb_prev   = rem_b_reg[i-1];
            assign qa_prev   = q_a_reg[i-1];
            assign qb_prev   = q_b_reg[i-1];
            assign dv_prev   = dv_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // shared shifted divisor for both lanes
        assign sub    = (2*W)'(dv_prev) << B;
        assign take_a = ra_prev >= sub;
        assign take_b = rb_prev >= sub;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (adv) begin
                valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_a_reg[i] <= take_a ? ra_prev - sub : ra_prev;
                rem_b_reg[i] <= take_b ? rb_prev - sub : rb_prev;
                q_a_reg[i]   <= take_a ? (qa_prev | ((W-1)'(1) << B)) : qa_prev;
                q_b_reg[i]   <= take_b ? (qb_prev | ((W-1)'(1) << B)) : qb_prev;
                dv_reg[i]    <= dv_prev;
                side_reg[i]  <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quot_a    = q_a_reg[N-1];
    assign quot_b    = q_b_reg[N-1];
    assign out_side  = side_reg[N-1];
endmodule

>>> hw/rtl/onb_cross.sv
// Back end: signed tangent, cross products, floor shift, saturation and row assembly.
module onb_cross
    import onb_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [W-2:0]           quot_a,
    input  logic [W-2:0]           quot_b,
    input  logic [FLAGS_W+3*W-1:0] in_side,
    output logic                   out_valid,
    output logic [W-1:0]           r00,
    output logic [W-1:0]           r01,
    output logic [W-1:0]           r02,
    output logic [W-1:0]           r10,
    output logic [W-1:0]           r11,
    output logic [W-1:0]           r12,
    output logic [W-1:0]           r20,
    output logic [W-1:0]           r21,
    output logic [W-1:0]           r22
);
    localparam int F = W - 2;

    onb_flags_t   fi;
    logic [W-1:0] qa_w, qb_w, sa, sb;

    assign fi   = onb_flags_t'(in_side[FLAGS_W+3*W-1:3*W]);
    assign qa_w = {1'b0, quot_a};
    assign qb_w = {1'b0, quot_b};
    assign sa   = fi.zero_len ? '0 : (fi.neg_a ? -qa_w : qa_w);
    assign sb   = fi.zero_len ? '0 : (fi.neg_b ? -qb_w : qb_w);

    // Stage 1: first tangent
    logic                v1_reg;
    logic signed [W-1:0] t0_reg, t1_reg, t2_reg, x1_reg, y1_reg, z1_reg;
    logic [1:0]          d1_reg;

    // Stage 2: products
    logic                v2_reg;
    logic signed [W-1:0] t0b_reg, t1b_reg, t2b_reg, x2_reg, y2_reg;
    logic [1:0]          d2_reg;
    logic signed [W-1:0] z2_reg;
    logic signed [2*W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg  <= sa;
            t1_reg  <= fi.sel_y ? '0 : sb;
            t2_reg  <= fi.sel_y ? sb : '0;
            x1_reg  <= in_side[W-1:0];
            y1_reg  <= in_side[2*W-1:W];
            z1_reg  <= in_side[3*W-1:2*W];
            d1_reg  <= fi.dim;
            p0_reg  <= y1_reg * t2_reg;
            p1_reg  <= z1_reg * t1_reg;
            p2_reg  <= z1_reg * t0_reg;
            p3_reg  <= x1_reg * t2_reg;
            p4_reg  <= x1_reg * t1_reg;
            p5_reg  <= y1_reg * t0_reg;
            t0b_reg <= t0_reg;
            t1b_reg <= t1_reg;
            t2b_reg <= t2_reg;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            d2_reg  <= d1_reg;
        end
    end

    // Stage 3: differences, floor shift and saturation
    logic signed [2*W:0] d0, d1, d2, s0, s1, s2;
    logic [W-1:0]        c0, c1, c2, neg_y;
    logic signed [W:0]   ny_neg;

    assign d0 = p0_reg - p1_reg;
    assign d1 = p2_reg - p3_reg;
    assign d2 = p4_reg - p5_reg;
    assign s0 = d0 >>> F;
    assign s1 = d1 >>> F;
    assign s2 = d2 >>> F;

    // value fits when all bits above the field's sign bit match it
    function automatic logic [W-1:0] sat_wide(input logic [2*W:0] v);
        logic fits;
        fits = (v[2*W:W-1] == '0) || (v[2*W:W-1] == '1);
        if (fits) sat_wide = v[W-1:0];
        else      sat_wide = v[2*W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    assign c0     = sat_wide(s0);
    assign c1     = sat_wide(s1);
    assign c2     = sat_wide(s2);
    assign ny_neg = -{y2_reg[W-1], y2_reg};
    assign neg_y  = (ny_neg[W] == ny_neg[W-1]) ? ny_neg[W-1:0]
                                               : {1'b0, {(W-1){1'b1}}};

    logic         v3_reg;
    logic [W-1:0] r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg;
    logic [W-1:0] r20_reg, r21_reg, r22_reg;
    logic [W-1:0] r00_next, r01_next, r02_next, r10_next, r11_next, r12_next;
    logic [W-1:0] r20_next, r21_next, r22_next;

    // row assembly by dimension
    always_comb begin
        r00_next = '0; r01_next = '0; r02_next = '0;
        r10_next = '0; r11_next = '0; r12_next = '0;
        r20_next = '0; r21_next = '0; r22_next = '0;
        unique case (d2_reg)
            DIM_NONE: begin
            end
            DIM_1: begin
                r00_next = x2_reg;
            end
            DIM_2: begin
                r00_next = x2_reg;
                r01_next = y2_reg;
                r10_next = neg_y;
                r11_next = x2_reg;
            end
            DIM_3: begin
                r00_next = x2_reg;
                r01_next = y2_reg;
                r02_next = z2_reg;
                r10_next = t0b_reg;
                r11_next = t1b_reg;
                r12_next = t2b_reg;
                r20_next = c0;
                r21_next = c1;
                r22_next = c2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r00_reg <= r00_next; r01_reg <= r01_next; r02_reg <= r02_next;
            r10_reg <= r10_next; r11_reg <= r11_next; r12_reg <= r12_next;
            r20_reg <= r20_next; r21_reg <= r21_next; r22_reg <= r22_next;
        end
    end

    assign out_valid = v3_reg;
    assign r00 = r00_reg; assign r01 = r01_reg; assign r02 = r02_reg;
    assign r10 = r10_reg; assign r11 = r11_reg; assign r12 = r12_reg;
    assign r20 = r20_reg; assign r21 = r21_reg; assign r22 = r22_reg;
endmodule

>>> hw/rtl/normal_to_orthonormal_basis.sv
// Throughput: one item per cycle unless stalled; the square root and divider are fully
// pipelined, one result bit per stage, which sets the depth.
// Stalls: the whole pipeline holds while a result waits and m_ready is low.
// Reset: aresetn synchronous, active low; clears all stage valid bits, data is not reset.
// Top level: normal vector in, 3x3 orthonormal frame out.
module normal_to_orthonormal_basis
    import onb_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_dimension,
    input  logic signed [COMPONENT_WIDTH-1:0] s_normal_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_normal_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_normal_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [COMPONENT_WIDTH-1:0] m_row0_col0,
    output logic signed [COMPONENT_WIDTH-1:0] m_row0_col1,
    output logic signed [COMPONENT_WIDTH-1:0] m_row0_col2,
    output logic signed [COMPONENT_WIDTH-1:0] m_row1_col0,
    output logic signed [COMPONENT_WIDTH-1:0] m_row1_col1,
    output logic signed [COMPONENT_WIDTH-1:0] m_row1_col2,
    output logic signed [COMPONENT_WIDTH-1:0] m_row2_col0,
    output logic signed [COMPONENT_WIDTH-1:0] m_row2_col1,
    output logic signed [COMPONENT_WIDTH-1:0] m_row2_col2
);
    localparam int W      = COMPONENT_WIDTH;
    localparam int SIDE_W = FLAGS_W + 3 * W;

    logic adv;
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;

    logic                pr_valid;
    logic [W-1:0]        pr_mag_a, pr_mag_b;
    logic [2*W-1:0]      pr_sum;
    logic [SIDE_W-1:0]   pr_side;

    onb_prep #(.W(W)) u_prep (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(s_valid && s_ready), .dimension(s_dimension),
        .nx(s_normal_x), .ny(s_normal_y), .nz(s_normal_z),
        .out_valid(pr_valid), .mag_a(pr_mag_a), .mag_b(pr_mag_b),
        .sum_sq(pr_sum), .side(pr_side)
    );

    logic                  sq_valid;
    logic [W-1:0]          sq_root;
    logic [2*W+SIDE_W-1:0] sq_side;

    onb_isqrt #(.W(W), .SIDE_W(2*W+SIDE_W)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(pr_valid), .radicand(pr_sum),
        .in_side({pr_mag_a, pr_mag_b, pr_side}),
        .out_valid(sq_valid), .root(sq_root), .out_side(sq_side)
    );

    logic              dv_valid;
    logic [W-2:0]      dv_qa, dv_qb;
    logic [SIDE_W-1:0] dv_side;

    onb_div #(.W(W), .SIDE_W(SIDE_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(sq_valid),
        .mag_a(sq_side[2*W+SIDE_W-1:W+SIDE_W]),
        .mag_b(sq_side[W+SIDE_W-1:SIDE_W]),
        .divisor(sq_root), .in_side(sq_side[SIDE_W-1:0]),
        .out_valid(dv_valid), .quot_a(dv_qa), .quot_b(dv_qb), .out_side(dv_side)
    );

    onb_cross #(.W(W)) u_cross (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(dv_valid), .quot_a(dv_qa), .quot_b(dv_qb), .in_side(dv_side),
        .out_valid(m_valid),
        .r00(m_row0_col0), .r01(m_row0_col1), .r02(m_row0_col2),
        .r10(m_row1_col0), .r11(m_row1_col1), .r12(m_row1_col2),
        .r20(m_row2_col0), .r21(m_row2_col1), .r22(m_row2_col2)
    );
endmodule

>>> hw/rtl/onb_checker.sv
// Port-level assertions for the orthonormal basis block, with its bind.
module onb_checker #(
    parameter int COMPONENT_WIDTH = 16
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [COMPONENT_WIDTH-1:0] m_row0_col0,
    input logic [COMPONENT_WIDTH-1:0] m_row2_col2
);
    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row0_col0) && $stable(m_row2_col2))
        else $error("result changed while stalled");

    // the block never refuses input with an empty output stage
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output");

    // input is refused only because of a stall
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without stall");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");
endmodule

bind normal_to_orthonormal_basis onb_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_onb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_row0_col0(m_row0_col0), .m_row2_col2(m_row2_col2)
);
